[hw/rtl/mbps_pkg.sv]
// Package for the memory byte pattern search block: widths, register
// indexes and the structs passed between the CSR file and the match logic.
// No dependencies.
package mbps_pkg;

   // Longest pattern the window can hold
   localparam int MAX_PATTERN_BYTES = 8;

   localparam int BYTE_W        = 8;
   localparam int ADDR_W        = 32;
   localparam int SEARCH_PAT_W  = 64;
   localparam int LEN_W         = 4;
   // Fill count saturates at MAX_PATTERN_BYTES; kept at the length width so
   // the two compare directly
   localparam int FILL_W        = LEN_W;
   localparam int WINDOW_W      = MAX_PATTERN_BYTES * BYTE_W;
   localparam int HIST_W        = (MAX_PATTERN_BYTES - 1) * BYTE_W;
   localparam int LEN_IDX_W     = $clog2(MAX_PATTERN_BYTES);

   // APB side: 64-bit registers at an 8-byte stride
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;
   localparam int REG_IDX_W     = 3;
   localparam int REG_IDX_LSB   = 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SEARCH_PATTERN = 3'd0,
      REG_PATTERN_LENGTH = 3'd1,
      REG_DOMAIN_FIRST   = 3'd2,
      REG_DOMAIN_LAST    = 3'd3,
      REG_RANGE_FIRST    = 3'd4,
      REG_RANGE_LAST     = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [SEARCH_PAT_W-1:0] search_pattern;
      logic [LEN_W-1:0]        pattern_length;
      logic [ADDR_W-1:0]       domain_first_address;
      logic [ADDR_W-1:0]       domain_last_address;
      logic [ADDR_W-1:0]       range_first_address;
      logic [ADDR_W-1:0]       range_last_address;
   } search_cfg_type;

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] start_address;
   } match_result_type;

endpackage

[hw/rtl/mbps_req_if.sv]
// Request channel interface of the pattern search: one memory byte per
// transaction. Depends on mbps_pkg.
interface mbps_req_if;
   import mbps_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   mem_byte;
   logic [ADDR_W-1:0]   byte_address;
   logic                scan_last;

   modport source (output valid, output mem_byte, output byte_address,
                   output scan_last, input ready);
   modport sink   (input valid, input mem_byte, input byte_address,
                   input scan_last, output ready);
endinterface

[hw/rtl/mbps_rsp_if.sv]
// Response channel interface of the pattern search: one match report per
// transaction. Depends on mbps_pkg.
interface mbps_rsp_if;
   import mbps_pkg::*;

   logic                valid;
   logic                ready;
   logic                match_found;
   logic [ADDR_W-1:0]   match_address;
   logic                scan_done;

   modport source (output valid, output match_found, output match_address,
                   output scan_done, input ready);
   modport sink   (input valid, input match_found, input match_address,
                   input scan_done, output ready);
endinterface

[hw/rtl/memory_byte_pattern_search.sv]
// Top level of the memory byte pattern search: input register, byte history,
// match logic and result register. Depends on mbps_pkg, mbps_req_if,
// mbps_rsp_if, mbps_csr and mbps_match.
//
//  channel       | direction | transaction
//  --------------+-----------+---------------------------------------------
//  req_channel   | in        | mem_byte, byte_address, scan_last
//  rsp_channel   | out       | match_found, match_address, scan_done
//  APB (psel...) | in/out    | 64-bit register write/read, 8-byte stride
//
// One transaction per cycle sustained while rsp_channel.ready holds; a result
// leaves after its byte passes the input register, then the result register.
// While a result waits on rsp_channel.ready, one more byte is still taken into
// the input register; with both registers full, req_channel.ready drops.
// Synchronous active-high reset clears the valid flags, the history and the
// fill count. A result with scan_done set clears the history for the next scan.
module memory_byte_pattern_search (
   input  logic                             clock,
   input  logic                             reset,
   mbps_req_if.sink                         req_channel,
   mbps_rsp_if.source                       rsp_channel,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mbps_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [mbps_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import mbps_pkg::*;

   search_cfg_type        cfg;
   match_result_type      result;

   // Input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]     s1_byte_ff;
   logic [ADDR_W-1:0]     s1_addr_ff;
   logic                  s1_last_ff;

   // Scan history
   logic [HIST_W-1:0]     hist_ff, hist_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [FILL_W-1:0]     fill_next;
   logic [WINDOW_W-1:0]   window;

   // Result stage
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_found_ff;
   logic [ADDR_W-1:0]     s2_addr_ff;
   logic                  s2_done_ff;

   logic                  advance;
   logic                  accept;

   mbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Handshake: stage 1 moves on when the result register is free or drains
   assign advance           = s1_valid_ff && (!s2_valid_ff || rsp_channel.ready);
   assign req_channel.ready = !s1_valid_ff || advance;
   assign accept            = req_channel.valid && req_channel.ready;

   // Window: history plus the byte in stage 1, newest in the low byte
   assign window    = {hist_ff, s1_byte_ff};
   assign fill_next = (fill_ff == FILL_W'(MAX_PATTERN_BYTES)) ? fill_ff :
                      fill_ff + FILL_W'(1);

   mbps_match u_match (
      .cfg          (cfg),
      .window       (window),
      .fill_count   (fill_next),
      .byte_address (s1_addr_ff),
      .result       (result)
   );

   // Next-state for control and history
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      if (advance) begin
         s2_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         s2_valid_in = 1'b0;
      end

      hist_in = hist_ff;
      fill_in = fill_ff;
      if (advance) begin
         if (s1_last_ff) begin
            hist_in = '0;
            fill_in = '0;
         end else begin
            hist_in = window[HIST_W-1:0];
            fill_in = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         hist_ff     <= '0;
         fill_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         hist_ff     <= hist_in;
         fill_ff     <= fill_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_channel.mem_byte;
         s1_addr_ff <= req_channel.byte_address;
         s1_last_ff <= req_channel.scan_last;
      end
      if (advance) begin
         s2_found_ff <= result.hit;
         s2_addr_ff  <= result.start_address;
         s2_done_ff  <= s1_last_ff;
      end
   end

   assign rsp_channel.valid         = s2_valid_ff;
   assign rsp_channel.match_found   = s2_found_ff;
   assign rsp_channel.match_address = s2_addr_ff;
   assign rsp_channel.scan_done     = s2_done_ff;

   // Fill count never passes the window size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_PATTERN_BYTES))
      else $error("fill count above window size");

   // End of scan clears the history
   a_scan_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (fill_ff == '0) && (hist_ff == '0))
      else $error("history not cleared after end of scan");

   // A refused byte means both stages are full and the result is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_channel.ready |-> s1_valid_ff && s2_valid_ff && !rsp_channel.ready)
      else $error("request stalled without a full pipeline");

   // No hit reports a start address, and no hit without a pattern
   a_no_hit_addr: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_found_ff) |-> (s2_addr_ff == '0))
      else $error("address reported without a match");

   a_hit_len: assert property (@(posedge clock) disable iff (reset)
      (advance && result.hit) |-> (cfg.pattern_length != '0) && (fill_next != '0))
      else $error("match with empty pattern or empty window");

endmodule

[hw/rtl/mbps_csr.sv]
// APB register file of the pattern search: pattern, length and address
// bounds. Depends on mbps_pkg.
module mbps_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mbps_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [mbps_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output mbps_pkg::search_cfg_type         cfg
);
   import mbps_pkg::*;

   search_cfg_type          cfg_ff;
   search_cfg_type          cfg_in;
   logic                    wr_en;
   csr_reg_type             reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = csr_reg_type'(paddr[REG_IDX_LSB +: REG_IDX_W]);
   assign cfg     = cfg_ff;

   // Register write decode; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SEARCH_PATTERN: cfg_in.search_pattern = pwdata[SEARCH_PAT_W-1:0];
            REG_PATTERN_LENGTH: cfg_in.pattern_length = pwdata[LEN_W-1:0];
            REG_DOMAIN_FIRST:   cfg_in.domain_first_address = pwdata[ADDR_W-1:0];
            REG_DOMAIN_LAST:    cfg_in.domain_last_address = pwdata[ADDR_W-1:0];
            REG_RANGE_FIRST:    cfg_in.range_first_address = pwdata[ADDR_W-1:0];
            REG_RANGE_LAST:     cfg_in.range_last_address = pwdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux, zero extended
   always_comb begin
      unique case (reg_idx)
         REG_SEARCH_PATTERN: prdata = CSR_DATA_W'(cfg_ff.search_pattern);
         REG_PATTERN_LENGTH: prdata = CSR_DATA_W'(cfg_ff.pattern_length);
         REG_DOMAIN_FIRST:   prdata = CSR_DATA_W'(cfg_ff.domain_first_address);
         REG_DOMAIN_LAST:    prdata = CSR_DATA_W'(cfg_ff.domain_last_address);
         REG_RANGE_FIRST:    prdata = CSR_DATA_W'(cfg_ff.range_first_address);
         REG_RANGE_LAST:     prdata = CSR_DATA_W'(cfg_ff.range_last_address);
         default:            prdata = '0;
      endcase
   end

endmodule

[hw/rtl/mbps_match.sv]
// Match decision for one window position: parallel byte compare for every
// pattern length plus the effective range checks. Depends on mbps_pkg.
module mbps_match (
   input  mbps_pkg::search_cfg_type            cfg,
   input  logic [mbps_pkg::WINDOW_W-1:0]       window,
   input  logic [mbps_pkg::FILL_W-1:0]         fill_count,
   input  logic [mbps_pkg::ADDR_W-1:0]         byte_address,
   output mbps_pkg::match_result_type          result
);
   import mbps_pkg::*;

   logic [LEN_W-1:0]              len;
   logic [LEN_W-1:0]              len_m1;
   logic [ADDR_W-1:0]             lo;
   logic [ADDR_W-1:0]             hi;
   logic [ADDR_W-1:0]             start;
   logic [MAX_PATTERN_BYTES-1:0]  len_hit;
   logic                          eq;
   logic                          hit;

   // Lengths above the window size use the full window
   assign len    = (cfg.pattern_length > LEN_W'(MAX_PATTERN_BYTES)) ?
                   LEN_W'(MAX_PATTERN_BYTES) : cfg.pattern_length;
   assign len_m1 = len - LEN_W'(1);
   assign start  = byte_address - ADDR_W'(len_m1);

   // Effective range; a range end of zero means the domain end
   always_comb begin
      lo = (cfg.domain_first_address > cfg.range_first_address) ?
           cfg.domain_first_address : cfg.range_first_address;
      hi = cfg.domain_last_address;
      if ((cfg.range_last_address != '0) &&
          (cfg.range_last_address < cfg.domain_last_address)) begin
         hi = cfg.range_last_address;
      end
   end

   // One compare set per length: pattern byte 0 meets the oldest byte used
   always_comb begin
      for (int l = 1; l <= MAX_PATTERN_BYTES; l++) begin
         eq = 1'b1;
         for (int i = 0; i < l; i++) begin
            if (window[BYTE_W*(l-1-i) +: BYTE_W] != cfg.search_pattern[BYTE_W*i +: BYTE_W]) begin
               eq = 1'b0;
            end
         end
         len_hit[l-1] = eq;
      end
   end

   assign hit = (len != '0) && (fill_count >= len) && (lo <= hi) &&
                (byte_address >= ADDR_W'(len_m1)) && (start >= lo) &&
                (byte_address <= hi) && len_hit[len_m1[LEN_IDX_W-1:0]];

   assign result.hit           = hit;
   assign result.start_address = hit ? start : '0;

endmodule

[tb/memory_byte_pattern_search_test.sv]
// Testbench for memory_byte_pattern_search: streams memory bytes, predicts every match
// report and compares it with what the block returns. Depends on mbps_pkg,
// mbps_req_if, mbps_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module memory_byte_pattern_search_test;
   import mbps_pkg::*;

   localparam int CLOCK_HALF_NS     = 5;
   localparam int RESET_CYCLES      = 5;
   localparam int DRAIN_CYCLES      = 8;
   localparam int LONG_HOLD_CYCLES  = 60;
   localparam int RANDOM_PHASES     = 6;
   localparam int ITEMS_PER_PHASE   = 85;
   localparam int TIMEOUT_NS        = 2_000_000;

   typedef struct {
      logic [BYTE_W-1:0] mem_byte;
      logic [ADDR_W-1:0] byte_address;
      logic              scan_last;
   } scan_byte_type;

   typedef struct {
      logic              match_found;
      logic [ADDR_W-1:0] match_address;
      logic              scan_done;
   } match_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mbps_req_if byte_bus ();
   mbps_rsp_if match_bus ();

   memory_byte_pattern_search dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (byte_bus),
      .rsp_channel (match_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #(CLOCK_HALF_NS) clock = ~clock;

   // Bytes waiting to be sent and match reports waiting to come back
   scan_byte_type    byte_stream[$];
   match_report_type pending_matches[$];

   // Search setup as last written, and the window history it implies
   logic [SEARCH_PAT_W-1:0] cfg_pattern      = '0;
   logic [LEN_W-1:0]        cfg_length       = '0;
   logic [ADDR_W-1:0]       cfg_domain_first = '0;
   logic [ADDR_W-1:0]       cfg_domain_last  = '0;
   logic [ADDR_W-1:0]       cfg_range_first  = '0;
   logic [ADDR_W-1:0]       cfg_range_last   = '0;
   logic [HIST_W-1:0]       history          = '0;
   logic [FILL_W-1:0]       fill_level       = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int long_hold_requests = 0;
   int long_hold_served = 0;
   int hold_left = 0;

   int bytes_queued = 0;
   int bytes_taken = 0;
   int reports_seen = 0;
   int hits_seen = 0;
   int scans_closed = 0;
   int setups_loaded = 0;
   int mismatch_count = 0;

   // Match report for one byte; advances the history and fill level
   function automatic match_report_type predict_match(logic [BYTE_W-1:0] mem_byte,
                                                      logic [ADDR_W-1:0] addr,
                                                      logic last);
      logic [WINDOW_W-1:0] window;
      logic [ADDR_W-1:0]   len, lo, hi, start;
      match_report_type    rpt;
      window = {history, mem_byte};
      len = (cfg_length > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : cfg_length;
      if (fill_level < MAX_PATTERN_BYTES) fill_level++;
      lo = (cfg_domain_first > cfg_range_first) ? cfg_domain_first : cfg_range_first;
      hi = cfg_domain_last;
      if (cfg_range_last != 0 && cfg_range_last < hi) hi = cfg_range_last;
      rpt.match_found = 1'b0;
      rpt.match_address = '0;
      rpt.scan_done = last;
      if (len != 0 && fill_level >= len && lo <= hi && addr >= len - 1) begin
         start = addr - (len - 1);
         if (start >= lo && addr <= hi) begin
            rpt.match_found = 1'b1;
            // oldest byte of the window lines up with pattern byte 0
            for (int i = 0; i < int'(len); i++) begin
               if (window[8*(int'(len) - 1 - i) +: 8] != cfg_pattern[8*i +: 8])
                  rpt.match_found = 1'b0;
            end
            if (rpt.match_found) rpt.match_address = start;
         end
      end
      if (last) begin
         history = '0;
         fill_level = '0;
      end else begin
         history = window[HIST_W-1:0];
      end
      return rpt;
   endfunction

   function automatic void report_mismatch(string field, logic [ADDR_W-1:0] want,
                                           logic [ADDR_W-1:0] got);
      if (mismatch_count < 10)
         $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, field, want, got);
      mismatch_count++;
   endfunction

   // Driver: records accepted bytes, then offers the next one unless idling
   always @(posedge clock) begin
      scan_byte_type nxt;
      if (reset) begin
         byte_bus.valid <= 1'b0;
      end else begin
         if (byte_bus.valid && byte_bus.ready) begin
            pending_matches.insert(pending_matches.size(),
                                   predict_match(byte_bus.mem_byte,
                                                 byte_bus.byte_address,
                                                 byte_bus.scan_last));
            bytes_taken++;
         end
         if (!byte_bus.valid || byte_bus.ready) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = byte_stream.pop_front();
               byte_bus.valid        <= 1'b1;
               byte_bus.mem_byte     <= nxt.mem_byte;
               byte_bus.byte_address <= nxt.byte_address;
               byte_bus.scan_last    <= nxt.scan_last;
            end else begin
               byte_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each match report, then picks the next ready value
   always @(posedge clock) begin
      match_report_type want;
      if (reset) begin
         match_bus.ready <= 1'b0;
      end else begin
         if (match_bus.valid && match_bus.ready) begin
            reports_seen++;
            if (match_bus.match_found) hits_seen++;
            if (match_bus.scan_done) scans_closed++;
            if (pending_matches.size() == 0) begin
               report_mismatch("report with no byte pending", '0, match_bus.match_address);
            end else begin
               want = pending_matches.pop_front();
               if (match_bus.match_found !== want.match_found)
                  report_mismatch("match_found", ADDR_W'(want.match_found),
                                  ADDR_W'(match_bus.match_found));
               if (match_bus.match_address !== want.match_address)
                  report_mismatch("match_address", want.match_address,
                                  match_bus.match_address);
               if (match_bus.scan_done !== want.scan_done)
                  report_mismatch("scan_done", ADDR_W'(want.scan_done),
                                  ADDR_W'(match_bus.scan_done));
            end
         end
         // long hold-off, counted here so the sender keeps pushing meanwhile
         if (hold_left != 0) begin
            match_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (long_hold_served != long_hold_requests) begin
            match_bus.ready <= 1'b0;
            long_hold_served <= long_hold_requests;
            hold_left <= LONG_HOLD_CYCLES;
         end else begin
            match_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // APB write: setup, then access; the register takes the value at the edge that ends the access
   task automatic write_register(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_SEARCH_PATTERN: cfg_pattern      = value;
         REG_PATTERN_LENGTH: cfg_length       = value[LEN_W-1:0];
         REG_DOMAIN_FIRST:   cfg_domain_first = value[ADDR_W-1:0];
         REG_DOMAIN_LAST:    cfg_domain_last  = value[ADDR_W-1:0];
         REG_RANGE_FIRST:    cfg_range_first  = value[ADDR_W-1:0];
         REG_RANGE_LAST:     cfg_range_last   = value[ADDR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_search_setup(input logic [SEARCH_PAT_W-1:0] pattern,
                                    input logic [LEN_W-1:0] len,
                                    input logic [ADDR_W-1:0] d_first,
                                    input logic [ADDR_W-1:0] d_last,
                                    input logic [ADDR_W-1:0] r_first,
                                    input logic [ADDR_W-1:0] r_last);
      write_register(REG_SEARCH_PATTERN, pattern);
      write_register(REG_PATTERN_LENGTH, {60'd0, len});
      write_register(REG_DOMAIN_FIRST, {32'd0, d_first});
      write_register(REG_DOMAIN_LAST, {32'd0, d_last});
      write_register(REG_RANGE_FIRST, {32'd0, r_first});
      write_register(REG_RANGE_LAST, {32'd0, r_last});
      setups_loaded++;
   endtask

   task automatic queue_byte(input logic [BYTE_W-1:0] value, input logic [ADDR_W-1:0] addr,
                             input logic last);
      scan_byte_type item;
      item.mem_byte = value;
      item.byte_address = addr;
      item.scan_last = last;
      byte_stream.insert(byte_stream.size(), item);
      bytes_queued++;
   endtask

   // Block is idle once every queued byte has come back as a report
   task automatic wait_until_drained();
      do @(posedge clock);
      while (byte_stream.size() != 0 || reports_seen != bytes_queued);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random setup, then scans around the domain with the pattern planted often
   task automatic queue_random_phase(input int item_goal, input bit with_long_hold);
      logic [ADDR_W-1:0]       d_first, d_last, r_first, r_last, span, base, addr;
      logic [SEARCH_PAT_W-1:0] pattern;
      logic [LEN_W-1:0]        len;
      logic [BYTE_W-1:0]       value;
      int eff_len, queued, scan_len, plant_pos, pick;
      pattern = {$urandom, $urandom};
      case ($urandom_range(9))
         0: len = '0;
         1: len = LEN_W'($urandom_range(15, 9));
         default: len = LEN_W'($urandom_range(MAX_PATTERN_BYTES, 1));
      endcase
      case ($urandom_range(3))
         0: d_first = $urandom_range(7);
         1: d_first = 32'hFFFF_FF00 | $urandom_range(255);
         default: d_first = $urandom;
      endcase
      span = $urandom_range(300, 16);
      d_last = d_first + span;
      if ($urandom_range(7) == 0) d_last = d_first - $urandom_range(40, 1);
      case ($urandom_range(7))
         0: r_first = '0;
         1: r_first = d_first - $urandom_range(24);
         7: r_first = $urandom;
         default: r_first = d_first + $urandom_range(24);
      endcase
      case ($urandom_range(7))
         0, 1: r_last = '0;
         2: r_last = d_last + $urandom_range(24);
         3: r_last = d_first + $urandom_range(24);
         default: r_last = d_last - $urandom_range(24);
      endcase
      load_search_setup(pattern, len, d_first, d_last, r_first, r_last);
      if (with_long_hold) long_hold_requests <= long_hold_requests + 1;

      eff_len = (len == 0 || len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(len);
      plant_pos = eff_len;
      queued = 0;
      while (queued < item_goal) begin
         scan_len = $urandom_range(40, 1);
         base = d_first + $urandom_range(span) - $urandom_range(8);
         for (int j = 0; j < scan_len; j++) begin
            addr = base + j;
            // occasional jump: the window should trust the stream regardless
            if ($urandom_range(19) == 0) addr = $urandom;
            if (plant_pos < eff_len) begin
               value = pattern[8*plant_pos +: 8];
               plant_pos++;
            end else if ($urandom_range(4) == 0) begin
               value = pattern[7:0];
               plant_pos = 1;
            end else if ($urandom_range(1) == 0) begin
               pick = $urandom_range(MAX_PATTERN_BYTES - 1);
               value = pattern[8*pick +: 8];
            end else begin
               value = BYTE_W'($urandom);
            end
            queue_byte(value, addr, j == scan_len - 1);
         end
         queued += scan_len;
      end
   endtask

   // Stimulus and verdict
   initial begin
      byte_bus.valid = 1'b0;
      byte_bus.mem_byte = '0;
      byte_bus.byte_address = '0;
      byte_bus.scan_last = 1'b0;
      match_bus.ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 23;
      recv_idle_pct = 52;

      // zero pattern: short history, address wrap, jump to the top address,
      // and the history clearing at the end of a scan
      load_search_setup(64'h0, 4'd3, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
      queue_byte(8'h00, 32'h0, 1'b0);
      queue_byte(8'h00, 32'h1, 1'b0);
      queue_byte(8'h00, 32'h2, 1'b0);
      queue_byte(8'h00, 32'hFFFF_FFFF, 1'b1);
      queue_byte(8'h00, 32'h10, 1'b0);
      queue_byte(8'h00, 32'h11, 1'b0);
      queue_byte(8'h00, 32'h12, 1'b1);
      wait_until_drained();

      // oversized length acts as full width; range start below domain is clamped
      load_search_setup(64'h8877_6655_4433_2211, 4'd12, 32'h100, 32'h1FF, 32'h80, 32'h107);
      for (int k = 0; k < MAX_PATTERN_BYTES; k++)
         queue_byte(BYTE_W'(8'h11 * (k + 1)), 32'h100 + k, 1'b0);
      queue_byte(8'h11, 32'h108, 1'b1);
      wait_until_drained();

      // domain with first above last: nothing matches
      load_search_setup(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 32'h200, 32'h1FF, 32'h0, 32'h0);
      queue_byte(8'hFF, 32'h200, 1'b0);
      queue_byte(8'hFF, 32'h1FF, 1'b1);
      wait_until_drained();

      // single-byte pattern against both ends of a narrowed range
      load_search_setup(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 32'h40, 32'h7F, 32'h50, 32'h60);
      queue_byte(8'hFF, 32'h4F, 1'b0);
      queue_byte(8'hFF, 32'h50, 1'b0);
      queue_byte(8'hFF, 32'h61, 1'b0);
      queue_byte(8'hFF, 32'h60, 1'b1);
      wait_until_drained();

      // zero length never hits
      load_search_setup(64'h0, 4'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0);
      queue_byte(8'h00, 32'h5, 1'b0);
      queue_byte(8'h00, 32'h6, 1'b1);
      wait_until_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES / 3) begin
            send_idle_pct = 52;
            recv_idle_pct = 23;
         end
         if (phase == 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         queue_random_phase(ITEMS_PER_PHASE,
                            phase == RANDOM_PHASES / 3 || phase == 2 * RANDOM_PHASES / 3);
         wait_until_drained();
      end

      $display("Run covered %0d byte transactions over %0d search setups and %0d scans,",
               bytes_taken, setups_loaded, scans_closed);
      $display("with %0d of %0d match reports carrying a hit.", hits_seen, reports_seen);
      if (mismatch_count == 0 && pending_matches.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d reports still pending", pending_matches.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
